// File: rtl/wvr_pkg.sv
// Shared constants for the weighted variance reduction block:
// field widths, status and register codes, parameter defaults. No dependencies.
`default_nettype none
package wvr_pkg;
	localparam int SAMPLE_W  = 32;
	localparam int SPREAD_W  = 63;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;

	localparam int DEF_MAX_SAMPLES = 1024;
	localparam int DEF_SAMPLE_BITS = 32;
	localparam int DEF_FRAC_BITS   = 16;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_UNDEF = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NEGW  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NORM     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SQRT     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OMIT     = 2'd3;

	localparam logic [SPREAD_W-1:0] SPREAD_MAX = '1;
endpackage
`default_nettype wire

// File: rtl/wvr_if.sv
// Valid/ready channel interfaces for sample items and result items.
// Depends on wvr_pkg for the field widths.
`default_nettype none
interface wvr_sample_if import wvr_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic signed [SAMPLE_W-1:0] weight;
	logic                       sample_invalid;
	logic                       last_sample;
	modport source (output valid, sample, weight, sample_invalid, last_sample, input ready);
	modport sink (input valid, sample, weight, sample_invalid, last_sample, output ready);
endinterface

interface wvr_result_if import wvr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SPREAD_W-1:0] spread;
	logic [STATUS_W-1:0] status;
	modport source (output valid, spread, status, input ready);
	modport sink (input valid, spread, status, output ready);
endinterface
`default_nettype wire

// File: rtl/weighted_variance_reduction.sv
// Weighted variance / standard deviation over a stored sample vector.
// Depends on wvr_pkg and the channel interfaces in wvr_if.sv.
//
// Usage: sample items arrive on the samples channel and are written to the
// on-chip store at one item per cycle. The item with last_sample set is stored
// too (items beyond MAX_SAMPLES are dropped) and starts the reduction, during
// which samples.ready is low. One result item (spread, status) then appears on
// the result channel and the store is empty for the next vector.
// The reduction is run by a sequencer, with one divider shared by both divides
// and one shift-add multiplier shared by both multiplies of pass two: pass one
// over the stored samples, the mean divide, pass two (two 64-step shift-add
// multiplies per counted sample), the variance divide and the optional square
// root. An undefined or negative-weight result skips everything after pass one.
// If the receiver stalls, the result waits in the output register; loading
// of the next vector goes on, and a finished reduction waits in place until
// the output register is free.
// Reset clears the configuration, the sample count and the output valid.
// The sample store needs no clearing.
`default_nettype none
module weighted_variance_reduction import wvr_pkg::*; #(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	wvr_sample_if.sink                samples,
	wvr_result_if.source              result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic                 cfg_data
);
	localparam int AW     = $clog2(MAX_SAMPLES);
	localparam int CW     = $clog2(MAX_SAMPLES + 1);
	localparam int GUARD  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam int ESH    = 2 * FRAC_BITS + 2 * GUARD - 32;
	localparam int ACC_W  = 64 + AW + 1;
	localparam logic [6:0] DIV_LAST = 7'd127;
	localparam logic [6:0] HALF_LAST = 7'd63;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_P1_RD  = 5'd1;
	localparam logic [4:0] S_P1_MUL = 5'd2;
	localparam logic [4:0] S_P1_ACC = 5'd3;
	localparam logic [4:0] S_CHK    = 5'd4;
	localparam logic [4:0] S_MDIV   = 5'd5;
	localparam logic [4:0] S_MEAN   = 5'd6;
	localparam logic [4:0] S_P2_RD  = 5'd7;
	localparam logic [4:0] S_P2_DEV = 5'd8;
	localparam logic [4:0] S_SQ     = 5'd9;
	localparam logic [4:0] S_WT     = 5'd10;
	localparam logic [4:0] S_P2_ACC = 5'd11;
	localparam logic [4:0] S_VSET   = 5'd12;
	localparam logic [4:0] S_VDIV   = 5'd13;
	localparam logic [4:0] S_VFIN   = 5'd14;
	localparam logic [4:0] S_SQRT   = 5'd15;
	localparam logic [4:0] S_SFIN   = 5'd16;
	localparam logic [4:0] S_DONE   = 5'd17;

	logic signed [SAMPLE_BITS-1:0] smp_mem [MAX_SAMPLES];
	logic signed [SAMPLE_BITS-1:0] wt_mem [MAX_SAMPLES];
	logic                          inv_mem [MAX_SAMPLES];
	logic signed [SAMPLE_BITS-1:0] rd_smp_q, rd_wt_q;
	logic                          rd_inv_q;

	logic [4:0]    state_q;
	logic [CW-1:0] cnt_q, idx_q;
	logic          weighted_q, norm_q, sqrt_q, omit_q;

	logic signed [63:0]      prod_q;
	logic signed [31:0]      wi_q;
	logic [63:0]             ws_q;
	logic signed [ACC_W-1:0] wvs_q;
	logic [CW-1:0]           vc_q;
	logic                    neg_q, inv_seen_q;
	logic [63:0]             d_q;
	logic signed [63:0]      mean_q;

	logic [127:0] nq_q;
	logic [63:0]  rem_q, dvs_q;
	logic [6:0]   k_q;

	logic [127:0] mul_a_q, acc_q, ss_q;
	logic [63:0]  mul_b_q, wq_q;
	logic         sat_q;

	logic [127:0] sq_n_q;
	logic [63:0]  sq_r_q;
	logic [65:0]  sq_rem_q;

	logic [SPREAD_W-1:0] res_spread_q, out_spread_q;
	logic [STATUS_W-1:0] res_status_q, out_status_q;
	logic                out_valid_q;

	logic in_acc, store_ok, counted;
	logic signed [31:0] wi32, x32;
	logic [64:0]  rem_sh;
	logic         div_ge;
	logic [63:0]  rem_n;
	logic [127:0] acc_n;
	logic [67:0]  sq_sh, sq_trial;
	logic         sq_ge;
	logic [ACC_W-1:0] mag;
	logic signed [63:0] dev;
	logic [63:0]  am;
	logic [127:0] ss_sum, vq;
	logic [63:0]  r_round;

	assign samples.ready = (state_q == S_IDLE);
	assign in_acc        = samples.valid && samples.ready;
	assign store_ok      = (cnt_q < CW'(MAX_SAMPLES));
	assign result.valid  = out_valid_q;
	assign result.spread = out_spread_q;
	assign result.status = out_status_q;

	always_ff @(posedge clk) begin
		if (in_acc && store_ok) begin
			smp_mem[cnt_q[AW-1:0]] <= samples.sample[SAMPLE_BITS-1:0];
			wt_mem[cnt_q[AW-1:0]]  <= samples.weight[SAMPLE_BITS-1:0];
			inv_mem[cnt_q[AW-1:0]] <= samples.sample_invalid;
		end
		rd_smp_q <= smp_mem[idx_q[AW-1:0]];
		rd_wt_q  <= wt_mem[idx_q[AW-1:0]];
		rd_inv_q <= inv_mem[idx_q[AW-1:0]];
	end

	always_comb begin
		counted  = !(omit_q && rd_inv_q);
		x32      = 32'(rd_smp_q);
		wi32     = weighted_q ? 32'(rd_wt_q) : 32'sd1;
		rem_sh   = {rem_q, nq_q[127]};
		div_ge   = (rem_sh >= {1'b0, dvs_q});
		rem_n    = div_ge ? 64'(rem_sh - {1'b0, dvs_q}) : rem_sh[63:0];
		acc_n    = {acc_q[126:0], 1'b0} + (mul_b_q[63] ? mul_a_q : 128'd0);
		sq_sh    = {sq_rem_q, sq_n_q[127:126]};
		sq_trial = {2'b00, sq_r_q, 2'b01};
		sq_ge    = (sq_sh >= sq_trial);
		mag      = wvs_q[ACC_W-1] ? ACC_W'(-wvs_q) : ACC_W'(wvs_q);
		dev      = (64'(rd_smp_q) <<< GUARD) - mean_q;
		am       = dev[63] ? 64'(-dev) : 64'(dev);
		ss_sum   = ss_q + acc_q;
		vq       = nq_q >> ESH;
		r_round  = sq_r_q + 64'((68'(sq_rem_q) > 68'(sq_r_q)) ? 1 : 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weighted_q <= 1'b0;
			norm_q     <= 1'b0;
			sqrt_q     <= 1'b0;
			omit_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WEIGHTED: weighted_q <= cfg_data;
				CFG_NORM:     norm_q     <= cfg_data;
				CFG_SQRT:     sqrt_q     <= cfg_data;
				CFG_OMIT:     omit_q     <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			// A finished reduction reloads the output register itself.
			if (out_valid_q && result.ready && state_q != S_DONE)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cnt_q <= cnt_q + CW'(store_ok);
						if (samples.last_sample) begin
							idx_q      <= '0;
							ws_q       <= '0;
							wvs_q      <= '0;
							vc_q       <= '0;
							neg_q      <= 1'b0;
							inv_seen_q <= 1'b0;
							state_q    <= S_P1_RD;
						end
					end
				end
				S_P1_RD: begin
					state_q <= (idx_q == cnt_q) ? S_CHK : S_P1_MUL;
				end
				S_P1_MUL: begin
					if (!counted) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_P1_RD;
					end else begin
						prod_q <= 64'(wi32) * 64'(x32);
						wi_q   <= wi32;
						vc_q   <= vc_q + 1'b1;
						if (wi32 < 0)
							neg_q <= 1'b1;
						if (rd_inv_q)
							inv_seen_q <= 1'b1;
						state_q <= S_P1_ACC;
					end
				end
				S_P1_ACC: begin
					// Sums past a negative weight are useless but harmless.
					ws_q    <= ws_q + 64'(wi_q);
					wvs_q   <= wvs_q + ACC_W'(prod_q);
					idx_q   <= idx_q + 1'b1;
					state_q <= S_P1_RD;
				end
				S_CHK: begin
					res_spread_q <= '0;
					if (neg_q) begin
						res_status_q <= STATUS_NEGW;
						state_q      <= S_DONE;
					end else if (vc_q == '0 || inv_seen_q || ws_q == '0 ||
							(!weighted_q && vc_q == CW'(1) && !norm_q)) begin
						res_status_q <= STATUS_UNDEF;
						state_q      <= S_DONE;
					end else begin
						res_status_q <= STATUS_OK;
						d_q   <= weighted_q ? ws_q :
							(norm_q ? 64'(vc_q) : 64'(vc_q - 1'b1));
						nq_q  <= (128'(mag) << (GUARD + 1)) + 128'(ws_q);
						dvs_q <= {ws_q[62:0], 1'b0};
						rem_q <= '0;
						k_q   <= '0;
						state_q <= S_MDIV;
					end
				end
				S_MDIV, S_VDIV: begin
					nq_q  <= {nq_q[126:0], div_ge};
					rem_q <= rem_n;
					k_q   <= k_q + 1'b1;
					if (k_q == DIV_LAST)
						state_q <= (state_q == S_MDIV) ? S_MEAN : S_VFIN;
				end
				S_MEAN: begin
					mean_q  <= wvs_q[ACC_W-1] ? -signed'(nq_q[63:0]) : signed'(nq_q[63:0]);
					idx_q   <= '0;
					ss_q    <= '0;
					sat_q   <= 1'b0;
					state_q <= S_P2_RD;
				end
				S_P2_RD: begin
					state_q <= (idx_q == cnt_q) ? S_VSET : S_P2_DEV;
				end
				S_P2_DEV: begin
					if (!counted) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_P2_RD;
					end else begin
						mul_a_q <= 128'(am);
						mul_b_q <= am;
						wq_q    <= weighted_q ? 64'(rd_wt_q) : 64'd1;
						acc_q   <= '0;
						k_q     <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (k_q == HALF_LAST) begin
						mul_a_q <= acc_n;
						mul_b_q <= wq_q;
						acc_q   <= '0;
						k_q     <= '0;
						state_q <= S_WT;
					end else begin
						mul_b_q <= {mul_b_q[62:0], 1'b0};
						acc_q   <= acc_n;
						k_q     <= k_q + 1'b1;
					end
				end
				S_WT: begin
					mul_b_q <= {mul_b_q[62:0], 1'b0};
					acc_q   <= acc_n;
					k_q     <= k_q + 1'b1;
					if (k_q == HALF_LAST)
						state_q <= S_P2_ACC;
				end
				S_P2_ACC: begin
					// Once the sum reaches 2^126 the result saturates for good.
					ss_q <= ss_sum;
					if (ss_sum[127:126] != 2'b00)
						sat_q <= 1'b1;
					idx_q   <= idx_q + 1'b1;
					state_q <= S_P2_RD;
				end
				S_VSET: begin
					if (sat_q) begin
						res_spread_q <= SPREAD_MAX;
						state_q      <= S_DONE;
					end else begin
						nq_q  <= {ss_q[126:0], 1'b0} + (128'(d_q) << ESH);
						dvs_q <= {d_q[62:0], 1'b0};
						rem_q <= '0;
						k_q   <= '0;
						state_q <= S_VDIV;
					end
				end
				S_VFIN: begin
					if (sqrt_q) begin
						if (vq[127:94] != '0) begin
							res_spread_q <= SPREAD_MAX;
							state_q      <= S_DONE;
						end else begin
							sq_n_q   <= vq << 32;
							sq_r_q   <= '0;
							sq_rem_q <= '0;
							k_q      <= '0;
							state_q  <= S_SQRT;
						end
					end else begin
						res_spread_q <= (vq[127:63] != '0) ? SPREAD_MAX : vq[62:0];
						state_q      <= S_DONE;
					end
				end
				S_SQRT: begin
					sq_n_q   <= {sq_n_q[125:0], 2'b00};
					sq_rem_q <= sq_ge ? 66'(sq_sh - sq_trial) : sq_sh[65:0];
					sq_r_q   <= {sq_r_q[62:0], sq_ge};
					k_q      <= k_q + 1'b1;
					if (k_q == HALF_LAST)
						state_q <= S_SFIN;
				end
				S_SFIN: begin
					// Round to nearest: bump the root when n exceeds r*r + r.
					res_spread_q <= r_round[63] ? SPREAD_MAX : r_round[62:0];
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q  <= 1'b1;
						out_spread_q <= res_spread_q;
						out_status_q <= res_status_q;
						cnt_q        <= '0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/wvr_checker.sv
// Port-level checks for weighted_variance_reduction, bound to the top level.
// Depends on wvr_pkg for the status codes.
`default_nettype none
module wvr_checker import wvr_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                in_last,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [SPREAD_W-1:0] out_spread,
	input wire logic [STATUS_W-1:0] out_status
);
	// A stalled result item stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_status == STATUS_OK || out_status == STATUS_UNDEF ||
			out_status == STATUS_NEGW))
		else $error("status code out of range");

	// Every failing status comes with a zero spread.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != STATUS_OK |-> out_spread == '0)
		else $error("nonzero spread with error status");

	// The item that closes a vector starts the reduction, so the input stalls.
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("input still ready after last item");
endmodule

bind weighted_variance_reduction wvr_checker u_wvr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.in_last   (samples.last_sample),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_spread(result.spread),
	.out_status(result.status)
);
`default_nettype wire

// File: tb/tb.sv
// Testbench for weighted_variance_reduction: directed vectors, a full-store
// vector and random vectors under several idling patterns, with a local
// predictor of spread and status. Depends on wvr_pkg and the interfaces in wvr_if.sv.
module tb import wvr_pkg::*; ();

	typedef struct packed {
		logic [SPREAD_W-1:0] spread;
		logic [STATUS_W-1:0] status;
	} spread_result_t;

	localparam int MAX_SAMPLES = DEF_MAX_SAMPLES;
	localparam logic [127:0] WIDE_ONES = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_WEIGHTED;
	logic cfg_data = 1'b0;

	wvr_sample_if s_if ();
	wvr_result_if r_if ();

	weighted_variance_reduction u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (s_if),
		.result   (r_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow configuration and the vector loaded so far.
	bit weighted_on, norm_by_count, sqrt_on, omit_nan;
	logic signed [31:0] vec_sample[$];
	logic signed [31:0] vec_weight[$];
	bit vec_nan[$];
	spread_result_t spread_expect_q[$];
	int fails = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	function automatic spread_result_t predict_spread();
		spread_result_t res;
		logic [63:0] wsum, d, am, r, c;
		logic signed [127:0] wvs;
		logic signed [63:0] wi, xs, p, mean, dev;
		logic [127:0] mag, q, ss, v, n, term;
		logic [128:0] acc;
		int vcnt;
		bit neg_seen, nan_seen, neg, sat;
		wsum = 0; wvs = 0; vcnt = 0; neg_seen = 0; nan_seen = 0;
		res.spread = '0;
		for (int i = 0; i < vec_sample.size(); i++) begin
			if (omit_nan && vec_nan[i]) continue;
			wi = weighted_on ? 64'(vec_weight[i]) : 64'sd1;
			if (wi < 0) neg_seen = 1;
			vcnt++;
			if (vec_nan[i]) nan_seen = 1;
			if (neg_seen) continue;
			xs = 64'(vec_sample[i]);
			wsum += wi;
			p = wi * xs;
			wvs = wvs + p;
		end
		if (neg_seen) begin
			res.status = STATUS_NEGW;
			return res;
		end
		if (vcnt == 0 || nan_seen || wsum == 0 ||
				(!weighted_on && vcnt == 1 && !norm_by_count)) begin
			res.status = STATUS_UNDEF;
			return res;
		end
		res.status = STATUS_OK;
		d = weighted_on ? wsum : (norm_by_count ? 64'(vcnt) : 64'(vcnt - 1));
		// Mean rounds half away from zero.
		neg = wvs[127];
		mag = neg ? 128'(-wvs) : 128'(wvs);
		q = ((mag << 1) + 128'(wsum)) / (128'(wsum) << 1);
		mean = q[63:0];
		if (neg) mean = -mean;
		ss = 0;
		for (int i = 0; i < vec_sample.size(); i++) begin
			if (omit_nan && vec_nan[i]) continue;
			wi = weighted_on ? 64'(vec_weight[i]) : 64'sd1;
			dev = 64'(vec_sample[i]) - mean;
			am = dev < 0 ? 64'(-dev) : 64'(dev);
			term = (128'(am) * 128'(am)) * 128'(wi);
			acc = 129'(ss) + 129'(term);
			ss = acc[128] ? WIDE_ONES : acc[127:0];
		end
		sat = ss[127:126] != 0;
		v = 0;
		if (!sat) v = ((ss << 1) + 128'(d)) / (128'(d) << 1);
		if (sqrt_on) begin
			if (sat || v[127:94] != 0) begin
				res.spread = SPREAD_MAX;
			end else begin
				n = v << 32;
				r = 0;
				for (int b = 63; b >= 0; b--) begin
					c = r | (64'd1 << b);
					if (128'(c) * 128'(c) <= n) r = c;
				end
				if (n > 128'(r) * 128'(r) + 128'(r)) r++;
				res.spread = r > 64'(SPREAD_MAX) ? SPREAD_MAX : r[62:0];
			end
		end else begin
			res.spread = (sat || v > 128'(SPREAD_MAX)) ? SPREAD_MAX : v[62:0];
		end
		return res;
	endfunction

	task automatic send_sample(input logic signed [31:0] x, input logic signed [31:0] w,
			input bit nan, input bit last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_if.valid = 1'b0;
			@(negedge clk);
		end
		s_if.valid = 1'b1;
		s_if.sample = x;
		s_if.weight = w;
		s_if.sample_invalid = nan;
		s_if.last_sample = last;
		do @(posedge clk); while (!s_if.ready);
		if (vec_sample.size() < MAX_SAMPLES) begin
			vec_sample = {vec_sample, x};
			vec_weight = {vec_weight, w};
			vec_nan = {vec_nan, nan};
		end
		if (last) begin
			spread_expect_q = {spread_expect_q, predict_spread()};
			vec_sample.delete();
			vec_weight.delete();
			vec_nan.delete();
		end
	endtask

	task automatic drain();
		@(negedge clk);
		s_if.valid = 1'b0;
		while (spread_expect_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_WEIGHTED: weighted_on = val;
			CFG_NORM: norm_by_count = val;
			CFG_SQRT: sqrt_on = val;
			default: omit_nan = val;
		endcase
	endtask

	task automatic set_mode(input bit wm, input bit nf, input bit sq, input bit om);
		drain();
		write_reg(CFG_WEIGHTED, wm);
		write_reg(CFG_NORM, nf);
		write_reg(CFG_SQRT, sq);
		write_reg(CFG_OMIT, om);
	endtask

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_weight();
		case ($urandom_range(29))
			0: return 32'h0;
			1: return $urandom | 32'h8000_0000;
			2, 3, 4: return 32'h7FFF_FFFF - $urandom_range(3);
			5, 6, 7, 8, 9: return 32'h0001_0000;
			10, 11, 12, 13, 14: return $urandom_range(1, 32'h0004_0000);
			default: return $urandom_range(1, 32'h7FFF_FFFF);
		endcase
	endfunction

	task automatic test_directed();
		set_mode(0, 0, 0, 0);
		send_sample(32'sh7FFF_FFFF, 32'sh0001_0000, 0, 0);
		send_sample(32'sh8000_0000, 32'sh0001_0000, 0, 1);
		// A lone sample divided by count minus one is undefined.
		send_sample(32'sh0003_0000, 32'sh8000_0000, 0, 1);
		set_mode(0, 1, 1, 0);
		send_sample(32'sh0003_0000, 32'sh0000_0000, 0, 1);
		send_sample(32'sh0001_0000, 32'sh0001_0000, 1, 0);
		send_sample(32'sh0002_0000, 32'sh0001_0000, 0, 1);
		set_mode(0, 1, 0, 1);
		send_sample(32'sh0005_0000, 32'sh0001_0000, 1, 0);
		send_sample(32'sh0001_8000, 32'sh0001_0000, 0, 0);
		send_sample(32'shFFFE_0000, 32'sh0001_0000, 0, 1);
		// Everything skipped leaves no samples counted.
		send_sample(32'sh0001_0000, 32'sh0001_0000, 1, 1);
		set_mode(1, 0, 1, 1);
		send_sample(32'sh0001_0000, 32'sh0002_0000, 0, 0);
		send_sample(32'sh0004_0000, 32'sh0001_0000, 0, 0);
		send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 1);
		send_sample(32'sh0001_0000, 32'sh0001_0000, 0, 0);
		send_sample(32'sh0002_0000, 32'shFFFF_0000, 0, 1);
		// A negative weight on a skipped sample does not count.
		send_sample(32'sh0001_0000, 32'sh8000_0000, 1, 0);
		send_sample(32'sh0002_0000, 32'sh0001_0000, 0, 1);
		send_sample(32'sh0001_0000, 32'sh0000_0000, 0, 0);
		send_sample(32'sh0002_0000, 32'sh0000_0000, 0, 1);
		set_mode(1, 1, 0, 0);
		send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0);
		send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 1);
		send_sample(32'sh0001_0000, 32'sh0001_0000, 0, 0);
		send_sample(32'sh0002_0000, 32'shFFFF_FFFF, 1, 1);
	endtask

	// Items past the store depth are dropped but the last one still ends the vector.
	task automatic test_store_full();
		set_mode(0, 0, 0, 0);
		for (int i = 0; i < MAX_SAMPLES + 6; i++)
			send_sample(rand_sample(), rand_weight(), 0, i == MAX_SAMPLES + 5);
	endtask

	task automatic test_random(input int idle_pct, input int stall_pct, input int n_items);
		int sent, len;
		sent = 0;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int blk = 0; blk < 4; blk++) begin
			set_mode($urandom_range(1), $urandom_range(1),
				$urandom_range(1), $urandom_range(1));
			while (sent < (blk + 1) * n_items / 4) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					send_sample(rand_sample(), rand_weight(), $urandom_range(9) == 0,
						i == len - 1);
				sent += len;
			end
		end
	endtask

	always @(negedge clk) r_if.ready = ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		spread_result_t exp_r;
		if (arst_n && r_if.valid && r_if.ready) begin
			if (spread_expect_q.size() == 0) begin
				$error("unexpected result item: spread %0h status %0d",
					r_if.spread, r_if.status);
				fails++;
			end else begin
				exp_r = spread_expect_q.pop_front();
				if (r_if.spread !== exp_r.spread) begin
					$error("spread: expected %0h, got %0h", exp_r.spread, r_if.spread);
					fails++;
				end
				if (r_if.status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, r_if.status);
					fails++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("weighted_variance_reduction regression: fail");
		$finish;
	end

	initial begin
		s_if.valid = 1'b0;
		s_if.sample = '0;
		s_if.weight = '0;
		s_if.sample_invalid = 1'b0;
		s_if.last_sample = 1'b0;
		r_if.ready = 1'b1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_store_full();
		test_random(0, 0, 50);
		test_random(84, 0, 50);
		test_random(0, 84, 50);
		test_random(6, 6, 50);
		drain();
		repeat (50) @(posedge clk);
		if (fails == 0)
			$display("weighted_variance_reduction regression: pass");
		else
			$display("weighted_variance_reduction regression: fail");
		$finish;
	end
endmodule
